### hdl/serial_to_char_lcd_bridge_core_assert.svh
// Assertion macros for the serial-to-LCD bridge checker.
// No dependencies; the user must have clk and arst_n in scope.
`ifndef SERIAL_TO_CHAR_LCD_BRIDGE_CORE_ASSERT_SVH
`define SERIAL_TO_CHAR_LCD_BRIDGE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define S2LCD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define S2LCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/s2lcd_pkg.sv
// Shared types and constants of the serial-to-LCD bridge.
// No dependencies; used by the engine, the result queue, the top level and the checker.
`default_nettype none

package s2lcd_pkg;

	// Input item kinds.
	typedef enum logic [1:0] {
		KIND_RX   = 2'd0,
		KIND_TICK = 2'd1,
		KIND_KEY  = 2'd2,
		KIND_NONE = 2'd3
	} in_kind_t;

	// Result item kinds.
	typedef enum logic [2:0] {
		OK_COMMAND   = 3'd0,
		OK_DATA      = 3'd1,
		OK_BACKLIGHT = 3'd2,
		OK_TX        = 3'd3,
		OK_OVERRUN   = 3'd4
	} out_kind_t;

	// Byte parser state.
	typedef enum logic [2:0] {
		PM_IDLE      = 3'b001,
		PM_CMD       = 3'b010,
		PM_BACKLIGHT = 3'b100
	} parse_mode_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WAIT = 1'b1;

	localparam int WAIT_W = 12;
	localparam logic [WAIT_W-1:0] LONG_WAIT_RESET  = 12'd2000;
	localparam logic [WAIT_W-1:0] SHORT_WAIT_RESET = 12'd40;

	localparam logic [7:0] PREFIX_COMMAND   = 8'hFE;
	localparam logic [7:0] PREFIX_BACKLIGHT = 8'hFD;
	localparam logic [7:0] KEYPAD_PREFIX    = 8'hFE;
	localparam logic [7:0] LONG_CMD_LIMIT   = 8'd4;

	// Result queue geometry.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef struct packed {
		out_kind_t  kind;
		logic [7:0] value;
		logic       last;
	} res_t;

	// Results caused by one accepted item (count is 0, 1 or 2).
	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
	} emit_t;

endpackage

`default_nettype wire

### hdl/s2lcd_engine.sv
// Parser, delay counter, pending transfer and keypad tracker of the bridge.
// Depends on s2lcd_pkg; produces up to two results for each accepted item.
`default_nettype none

module s2lcd_engine import s2lcd_pkg::*; #(
	parameter int ELAPSED_BITS = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WAIT_W-1:0]    cfg_data,
	input  wire logic                 item_fire,
	input  wire logic [1:0]           kind,
	input  wire logic [7:0]           rx_byte,
	input  wire logic                 key_pressed,
	input  wire logic [3:0]           key_index,
	output emit_t                     emit
);

	localparam int CMP_W = (ELAPSED_BITS > WAIT_W) ? ELAPSED_BITS : WAIT_W;

	logic [WAIT_W-1:0]       long_wait_q, short_wait_q;
	parse_mode_t             mode_q, mode_d;
	logic [ELAPSED_BITS-1:0] elapsed_q, elapsed_d;
	logic                    pend_valid_q, pend_valid_d;
	logic                    pend_cmd_q, pend_cmd_d;
	logic [7:0]              pend_value_q, pend_value_d;
	logic                    pend_long_q, pend_long_d;
	logic                    prev_pressed_q, prev_pressed_d;
	logic [3:0]              prev_index_q, prev_index_d;

	logic                    rx_is_cmd, rx_long, rx_ready;
	logic [WAIT_W-1:0]       rx_wait, pend_wait;
	logic [ELAPSED_BITS-1:0] tick_elapsed;
	logic                    tick_fire;
	logic [3:0]              key_idx;
	logic                    key_changed;
	logic [7:0]              key_code;
	out_kind_t               rx_lcd_kind, pend_lcd_kind;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_wait_q  <= LONG_WAIT_RESET;
			short_wait_q <= SHORT_WAIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LONG_WAIT:  long_wait_q  <= cfg_data;
				CFG_SHORT_WAIT: short_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Delay checks for a new byte transfer and for the pending one on a tick.
	assign rx_is_cmd    = (mode_q == PM_CMD);
	assign rx_long      = rx_is_cmd && (rx_byte < LONG_CMD_LIMIT);
	assign rx_wait      = rx_long ? long_wait_q : short_wait_q;
	assign rx_ready     = CMP_W'(elapsed_q) >= CMP_W'(rx_wait);
	assign rx_lcd_kind  = rx_is_cmd ? OK_COMMAND : OK_DATA;
	assign tick_elapsed = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
	assign pend_wait    = pend_long_q ? long_wait_q : short_wait_q;
	assign tick_fire    = pend_valid_q && (CMP_W'(tick_elapsed) >= CMP_W'(pend_wait));
	assign pend_lcd_kind = pend_cmd_q ? OK_COMMAND : OK_DATA;

	// Keypad change detection and scan code.
	assign key_idx     = key_pressed ? key_index : 4'd0;
	assign key_changed = (key_pressed != prev_pressed_q) || (key_idx != prev_index_q);
	assign key_code    = {2'b00, key_idx[1:0], 4'(4'b0001 << key_idx[3:2])};

	// Next state and results for one item.
	always_comb begin
		mode_d         = mode_q;
		elapsed_d      = elapsed_q;
		pend_valid_d   = pend_valid_q;
		pend_cmd_d     = pend_cmd_q;
		pend_value_d   = pend_value_q;
		pend_long_d    = pend_long_q;
		prev_pressed_d = prev_pressed_q;
		prev_index_d   = prev_index_q;
		emit.count        = 2'd0;
		emit.first.kind   = OK_OVERRUN;
		emit.first.value  = rx_byte;
		emit.first.last   = 1'b1;
		emit.second.kind  = OK_TX;
		emit.second.value = key_code;
		emit.second.last  = 1'b1;

		case (in_kind_t'(kind))
			KIND_RX: begin
				if (pend_valid_q) begin
					emit.count = 2'd1;
				end else begin
					case (mode_q)
						PM_CMD: begin
							mode_d = PM_IDLE;
						end
						PM_BACKLIGHT: begin
							mode_d           = PM_IDLE;
							emit.count       = 2'd1;
							emit.first.kind  = OK_BACKLIGHT;
						end
						default: begin
							if (rx_byte == PREFIX_COMMAND) begin
								mode_d = PM_CMD;
							end else if (rx_byte == PREFIX_BACKLIGHT) begin
								mode_d = PM_BACKLIGHT;
							end else begin
								mode_d = PM_IDLE;
							end
						end
					endcase
					// An LCD transfer goes out now or is held pending.
					if (rx_is_cmd || (mode_q != PM_BACKLIGHT && rx_byte != PREFIX_COMMAND
							&& rx_byte != PREFIX_BACKLIGHT)) begin
						if (rx_ready) begin
							elapsed_d       = '0;
							emit.count      = 2'd1;
							emit.first.kind = rx_lcd_kind;
						end else begin
							pend_valid_d = 1'b1;
							pend_cmd_d   = rx_is_cmd;
							pend_value_d = rx_byte;
							pend_long_d  = rx_long;
						end
					end
				end
			end
			KIND_TICK: begin
				if (tick_fire) begin
					pend_valid_d     = 1'b0;
					elapsed_d        = '0;
					emit.count       = 2'd1;
					emit.first.kind  = pend_lcd_kind;
					emit.first.value = pend_value_q;
				end else begin
					elapsed_d = tick_elapsed;
				end
			end
			KIND_KEY: begin
				prev_pressed_d = key_pressed;
				prev_index_d   = key_idx;
				if (key_changed && key_pressed) begin
					emit.count       = 2'd2;
					emit.first.kind  = OK_TX;
					emit.first.value = KEYPAD_PREFIX;
					emit.first.last  = 1'b0;
				end
			end
			default: ;
		endcase

		if (!item_fire) begin
			emit.count = 2'd0;
		end
	end

	// State registers, updated only on an accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= PM_IDLE;
			elapsed_q      <= '1;
			pend_valid_q   <= 1'b0;
			pend_cmd_q     <= 1'b0;
			pend_value_q   <= 8'd0;
			pend_long_q    <= 1'b0;
			prev_pressed_q <= 1'b0;
			prev_index_q   <= 4'd0;
		end else if (item_fire) begin
			mode_q         <= mode_d;
			elapsed_q      <= elapsed_d;
			pend_valid_q   <= pend_valid_d;
			pend_cmd_q     <= pend_cmd_d;
			pend_value_q   <= pend_value_d;
			pend_long_q    <= pend_long_d;
			prev_pressed_q <= prev_pressed_d;
			prev_index_q   <= prev_index_d;
		end
	end

endmodule

`default_nettype wire

### hdl/s2lcd_res_fifo.sv
// Result queue of the bridge: takes up to two results a cycle, hands out one unless stalled.
// Depends on s2lcd_pkg for the result and emit types.
`default_nettype none

module s2lcd_res_fifo import s2lcd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  emit_t     emit,
	output logic      full2,
	output logic      out_valid,
	input  wire logic out_stall,
	output res_t      head
);

	res_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] rd_ptr_q, wr_ptr_q, wr_ptr_p1;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign out_valid = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	// Fewer than two free slots: no new item can be taken.
	assign full2     = (count_q > FIFO_CNT_W'(FIFO_DEPTH - 2));

	// Storage writes; the head slot is never written while occupied.
	always_ff @(posedge clk) begin
		if (emit.count != 2'd0) begin
			mem_q[wr_ptr_q] <= emit.first;
		end
		if (emit.count == 2'd2) begin
			mem_q[wr_ptr_p1] <= emit.second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(emit.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FIFO_CNT_W'(emit.count) - FIFO_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

### hdl/serial_to_char_lcd_bridge_core.sv
// Serial-to-character-LCD bridge, top level.
// Input channel (in_valid/in_stall) carries one item per cycle unless stalled:
// a serial rx byte, a one-microsecond tick or a keypad sample, selected by kind.
// Output channel (out_valid/out_stall) carries LCD commands, LCD data, backlight
// values, serial tx bytes and overrun reports, with last set on the final result
// of each item. An item causes zero, one or two results.
// Latency: with the queue empty, a result is offered in the cycle after its item
// is accepted; otherwise it waits behind the results already queued.
// Throughput: one item per cycle; the rate is set by the four-entry result queue,
// which takes two results a cycle and hands out one. The queue absorbs the second
// result of an isolated keypad press; over a long run of items that each make a
// result, with the output never stalled, every keypad press costs an input stall.
// in_stall rises when the queue has fewer than two free entries.
// When the receiver stalls, the offered result holds and the queue fills, then
// in_stall is raised; no result is lost.
// Configuration: cfg_we with cfg_index 0 (long wait) or 1 (short wait) and
// cfg_data; the user must write only while the block is idle (not enforced).
// Reset: arst_n clears the parser, empties the queue, saturates the delay counter,
// and loads the waits with 2000 and 40 microseconds.
`default_nettype none

module serial_to_char_lcd_bridge_core import s2lcd_pkg::*; #(
	parameter int ELAPSED_BITS = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WAIT_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           kind,
	input  wire logic [7:0]           rx_byte,
	input  wire logic                 key_pressed,
	input  wire logic [3:0]           key_index,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [2:0]                out_kind,
	output logic [7:0]                out_value,
	output logic                      last
);

	logic  item_fire;
	emit_t emit;
	res_t  head;

	assign item_fire = in_valid && !in_stall;

	// Per-item processing.
	s2lcd_engine #(
		.ELAPSED_BITS (ELAPSED_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_fire   (item_fire),
		.kind        (kind),
		.rx_byte     (rx_byte),
		.key_pressed (key_pressed),
		.key_index   (key_index),
		.emit        (emit)
	);

	// Result queue toward the output channel.
	s2lcd_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.full2     (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign out_kind  = head.kind;
	assign out_value = head.value;
	assign last      = head.last;

endmodule

`default_nettype wire

### hdl/s2lcd_checker.sv
// Port-level checker of the serial-to-LCD bridge, bound to the top level.
// Depends on s2lcd_pkg and the assertion macro header.
`default_nettype none

`include "serial_to_char_lcd_bridge_core_assert.svh"

module s2lcd_checker import s2lcd_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] out_kind,
	input wire logic [7:0] out_value,
	input wire logic       last
);

	// A stalled result holds.
	`S2LCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_value) && $stable(last), "stalled result changed")

	// Only the keypad prefix is a non-final result.
	`S2LCD_ASSERT_SAME(a_not_last_prefix, out_valid && !last, out_kind == OK_TX && out_value == KEYPAD_PREFIX, "non-final result is not the keypad prefix")

	// The keypad prefix is followed at once by its final scan code.
	`S2LCD_ASSERT_NEXT(a_prefix_pair, out_valid && !out_stall && !last, out_valid && last && out_kind == OK_TX, "keypad scan code missing after prefix")

endmodule

bind serial_to_char_lcd_bridge_core s2lcd_checker u_checker (.*);

`default_nettype wire
